FILE: sv/spcd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spcd_pkg
// Shared types, constants and helpers of the sphere/plate contact detector.
// ----------------------------------------------------------------------------
package spcd_pkg;

  // configuration register map, one word per register
  typedef enum logic [2:0] {
    REG_AXIS_Z_X,
    REG_AXIS_Z_Y,
    REG_AXIS_Z_Z,
    REG_AXIS_X_X,
    REG_AXIS_X_Y,
    REG_AXIS_X_Z,
    REG_PLATE_WIDTH,
    REG_PLATE_LENGTH
  } reg_e;

  // pi in Q2.30, rounded
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  // unit length in Q1.14
  localparam int Q14_ONE = 16384;
  // rounding half for a shift by 14
  localparam int RND_HALF = 8192;
  localparam logic [47:0] AREA_MAX = '1;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // one contact pair
  typedef struct packed {
    logic signed [31:0] sphere_x;
    logic signed [31:0] sphere_y;
    logic signed [31:0] sphere_z;
    logic [30:0]        sphere_radius;
    logic signed [31:0] plate_x;
    logic signed [31:0] plate_y;
    logic signed [31:0] plate_z;
    logic [30:0]        plate_height;
    logic               prev_active;
  } spcd_in_t;

  // one contact result
  typedef struct packed {
    logic signed [31:0] impact_depth;
    logic [47:0]        overlap_area;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] impact_x;
    logic signed [31:0] impact_y;
    logic signed [31:0] impact_z;
    logic               active;
    logic               unbalance;
  } spcd_out_t;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/spcd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spcd_in_if / spcd_out_if
// Valid/ready channels that carry contact pairs in and contact results out.
// ----------------------------------------------------------------------------
interface spcd_in_if;
  import spcd_pkg::*;
  logic     valid;
  logic     ready;
  spcd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spcd_out_if;
  import spcd_pkg::*;
  logic      valid;
  logic      ready;
  spcd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/sphere_plate_contact_detect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_plate_contact_detect
// Closest-point contact test of a sphere against a thin rectangular plate.
// ----------------------------------------------------------------------------
// Usage
//   in_i   : one sphere/plate pair per item (valid/ready, accepted when both high)
//   out_o  : one contact result per item, in item order
//   APB    : plate axes and extents; write only while no item is in flight
// Throughput: one item per cycle unless stalled. Every stage holds one multiply, one wide
//   add/compare, one step of the square root or one quotient bit.
// Pipeline: 12 projection/gap stages, 32 square-root steps, 16 quotient-bit steps
//   of the three direction dividers, 4 length/area/impact stages, then the output
//   register.
// Stall: the pipeline advances as one; while out_o is stalled it keeps taking
//   items until its last stage holds a finished result, then drops in_i.ready.
// Reset: clears all valid bits and returns the registers to a unit plate of
//   width and length 1.0 lying in the xy plane.
// ----------------------------------------------------------------------------
module sphere_plate_contact_detect #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  spcd_in_if.sink          in_i,
  spcd_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import spcd_pkg::*;

  localparam int MW = 58;
  localparam int NUMW = 55;
  localparam int QW = 64 - COORD_FRAC_BITS;
  localparam int AHW = QW + 16;
  localparam int TOTW = QW + 33;
  localparam int AFW = TOTW - 30;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 16;

  localparam int S_DZ = 1;
  localparam int S_T = 2;
  localparam int S_TZ = 3;
  localparam int S_P = 4;
  localparam int S_PXY = 5;
  localparam int S_AXY = 6;
  localparam int S_BXY = 7;
  localparam int S_GAP = 8;
  localparam int S_K = 9;
  localparam int S_SQ = 10;
  localparam int S_N = 11;
  localparam int S_SQRT0 = 12;
  localparam int S_LEN = S_SQRT0 + SQRT_STEPS;
  localparam int S_DIV0 = S_LEN + 1;
  localparam int S_DIR = S_DIV0 + DIV_STEPS;
  localparam int S_MUL = S_DIR + 1;
  localparam int S_FIN = S_MUL + 1;
  localparam int NSTG = S_FIN + 1;

  // everything one item carries down the pipeline
  typedef struct {
    logic signed [31:0]    ca [3];
    logic [30:0]           r;
    logic [29:0]           hh;
    logic                  prev;
    logic signed [32:0]    d [3];
    logic signed [MW-1:0]  mw [3];
    logic signed [MW-1:0]  mv [3];
    logic signed [35:0]    t;
    logic signed [38:0]    p [3];
    logic signed [30:0]    ax;
    logic signed [30:0]    ay;
    logic                  neg [3];
    logic [37:0]           mag [3];
    logic [2:0]            k;
    logic [30:0]           sm [3];
    logic [61:0]           sq [3];
    logic [63:0]           n;
    logic [63:0]           res;
    logic [38:0]           len;
    logic signed [40:0]    e;
    logic [NUMW-1:0]       num [3];
    logic [15:0]           quo [3];
    logic signed [15:0]    dir [3];
    logic [63:0]           prod;
    logic                  epos;
    logic                  apos;
    logic signed [32:0]    w;
    logic signed [48:0]    wd [3];
    logic [AHW-1:0]        ah;
    logic [47:0]           al;
    logic [47:0]           area;
    logic signed [31:0]    depth;
    logic signed [31:0]    imp [3];
  } tok_t;

  // configuration registers
  logic signed [15:0] az_q [3];
  logic signed [15:0] axx_q [3];
  logic [30:0]        width_q;
  logic [30:0]        length_q;
  logic signed [19:0] y_d [3];
  logic signed [19:0] y_q [3];

  // pipeline
  tok_t            tok_d [NSTG];
  tok_t            tok_q [NSTG];
  logic [NSTG-1:0] vld_q;
  logic            en;
  logic            take;
  spcd_out_t       out_d;
  spcd_out_t       out_data_q;
  logic            out_vld_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_q[0]  <= '0;
      az_q[1]  <= '0;
      az_q[2]  <= 16'(Q14_ONE);
      axx_q[0] <= 16'(Q14_ONE);
      axx_q[1] <= '0;
      axx_q[2] <= '0;
      width_q  <= 31'd65536;
      length_q <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      case (reg_e'(paddr[4:2]))
        REG_AXIS_Z_X:     az_q[0]  <= pwdata[15:0];
        REG_AXIS_Z_Y:     az_q[1]  <= pwdata[15:0];
        REG_AXIS_Z_Z:     az_q[2]  <= pwdata[15:0];
        REG_AXIS_X_X:     axx_q[0] <= pwdata[15:0];
        REG_AXIS_X_Y:     axx_q[1] <= pwdata[15:0];
        REG_AXIS_X_Z:     axx_q[2] <= pwdata[15:0];
        REG_PLATE_WIDTH:  width_q  <= pwdata[30:0];
        REG_PLATE_LENGTH: length_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_AXIS_Z_X:     prdata = 32'(unsigned'(az_q[0]));
      REG_AXIS_Z_Y:     prdata = 32'(unsigned'(az_q[1]));
      REG_AXIS_Z_Z:     prdata = 32'(unsigned'(az_q[2]));
      REG_AXIS_X_X:     prdata = 32'(unsigned'(axx_q[0]));
      REG_AXIS_X_Y:     prdata = 32'(unsigned'(axx_q[1]));
      REG_AXIS_X_Z:     prdata = 32'(unsigned'(axx_q[2]));
      REG_PLATE_WIDTH:  prdata = 32'(width_q);
      REG_PLATE_LENGTH: prdata = 32'(length_q);
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // plate y axis = z cross x, refreshed every cycle from the registers
  always_comb begin
    logic signed [33:0] cr [3];
    cr[0] = 34'(az_q[1]) * 34'(axx_q[2]) - 34'(az_q[2]) * 34'(axx_q[1]);
    cr[1] = 34'(az_q[2]) * 34'(axx_q[0]) - 34'(az_q[0]) * 34'(axx_q[2]);
    cr[2] = 34'(az_q[0]) * 34'(axx_q[1]) - 34'(az_q[1]) * 34'(axx_q[0]);
    for (int i = 0; i < 3; i++) begin
      y_d[i] = 20'((cr[i] + RND_HALF) >>> 14);
    end
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  // handshake: the whole pipeline moves unless its last stage is blocked
  assign take = !out_vld_q || out_o.ready;
  assign en = take || !vld_q[NSTG-1];
  assign in_i.ready = en;

  // stage logic
  always_comb begin
    logic signed [MW-1:0] sx;
    logic signed [MW-1:0] sy;
    logic signed [MW-1:0] hx;
    logic signed [MW-1:0] hy;
    logic signed [37:0]   g;
    logic [37:0]          orm;
    logic [63:0]          bitv;
    logic [NUMW-1:0]      dv;
    logic [15:0]          qc;
    logic signed [42:0]   bv;
    logic [63:0]          qa;
    logic [TOTW-1:0]      tot;
    logic [AFW-1:0]       af;
    logic signed [35:0]   iv;
    int                   j;

    sx = '0;
    sy = '0;
    g = '0;
    orm = '0;
    bitv = '0;
    dv = '0;
    qc = '0;
    bv = '0;
    qa = '0;
    tot = '0;
    af = '0;
    iv = '0;
    j = 0;
    hx = MW'(width_q[30:1]);
    hy = MW'(length_q[30:1]);

    // entry: centre offset
    tok_d[0] = '{default: '0};
    tok_d[0].ca[0] = in_i.data.sphere_x;
    tok_d[0].ca[1] = in_i.data.sphere_y;
    tok_d[0].ca[2] = in_i.data.sphere_z;
    tok_d[0].d[0] = 33'(in_i.data.sphere_x) - 33'(in_i.data.plate_x);
    tok_d[0].d[1] = 33'(in_i.data.sphere_y) - 33'(in_i.data.plate_y);
    tok_d[0].d[2] = 33'(in_i.data.sphere_z) - 33'(in_i.data.plate_z);
    tok_d[0].r = in_i.data.sphere_radius;
    tok_d[0].hh = in_i.data.plate_height[30:1];
    tok_d[0].prev = in_i.data.prev_active;

    for (int s = 1; s < NSTG; s++) begin
      tok_d[s] = tok_q[s-1];
      if (s >= S_SQRT0 && s < S_SQRT0 + SQRT_STEPS) begin
        // one digit of the integer square root
        j = s - S_SQRT0;
        bitv = 64'(1) << (62 - 2 * j);
        if (tok_d[s].n >= tok_d[s].res + bitv) begin
          tok_d[s].n = tok_d[s].n - (tok_d[s].res + bitv);
          tok_d[s].res = (tok_d[s].res >> 1) + bitv;
        end else begin
          tok_d[s].res = tok_d[s].res >> 1;
        end
      end else if (s >= S_DIV0 && s < S_DIV0 + DIV_STEPS) begin
        // one quotient bit of each direction component
        j = DIV_STEPS - 1 - (s - S_DIV0);
        dv = NUMW'(tok_d[s].len) << j;
        for (int i = 0; i < 3; i++) begin
          if (tok_d[s].num[i] >= dv) begin
            tok_d[s].num[i] = tok_d[s].num[i] - dv;
            tok_d[s].quo[i] = tok_d[s].quo[i] | (16'(1) << j);
          end
        end
      end else begin
        case (s)
          // offset along the normal
          S_DZ: begin
            for (int i = 0; i < 3; i++) begin
              tok_d[s].mw[i] = MW'(tok_d[s].d[i]) * MW'(az_q[i]);
            end
          end
          S_T: begin
            tok_d[s].t = 36'((tok_d[s].mw[0] + tok_d[s].mw[1] + tok_d[s].mw[2]
                              + RND_HALF) >>> 14);
          end
          S_TZ: begin
            for (int i = 0; i < 3; i++) begin
              tok_d[s].mw[i] = MW'(tok_d[s].t) * MW'(az_q[i]);
            end
          end
          // projection onto the plate plane
          S_P: begin
            for (int i = 0; i < 3; i++) begin
              tok_d[s].p[i] = 39'(MW'(tok_d[s].d[i]) - ((tok_d[s].mw[i] + RND_HALF) >>> 14));
            end
          end
          S_PXY: begin
            for (int i = 0; i < 3; i++) begin
              tok_d[s].mw[i] = MW'(tok_d[s].p[i]) * MW'(axx_q[i]);
              tok_d[s].mv[i] = MW'(tok_d[s].p[i]) * MW'(y_q[i]);
            end
          end
          // in-plane offsets clamped to the half extents
          S_AXY: begin
            sx = (tok_d[s].mw[0] + tok_d[s].mw[1] + tok_d[s].mw[2] + RND_HALF) >>> 14;
            sy = (tok_d[s].mv[0] + tok_d[s].mv[1] + tok_d[s].mv[2] + RND_HALF) >>> 14;
            if (sx < -hx) sx = -hx;
            if (sx > hx) sx = hx;
            if (sy < -hy) sy = -hy;
            if (sy > hy) sy = hy;
            tok_d[s].ax = 31'(sx);
            tok_d[s].ay = 31'(sy);
          end
          S_BXY: begin
            for (int i = 0; i < 3; i++) begin
              tok_d[s].mw[i] = MW'(axx_q[i]) * MW'(tok_d[s].ax);
              tok_d[s].mv[i] = MW'(y_q[i]) * MW'(tok_d[s].ay);
            end
          end
          // gap vector from the sphere centre to the closest point
          S_GAP: begin
            for (int i = 0; i < 3; i++) begin
              g = 38'(((tok_d[s].mw[i] + tok_d[s].mv[i] + RND_HALF) >>> 14)
                      - MW'(tok_d[s].d[i]));
              tok_d[s].neg[i] = g < 0;
              tok_d[s].mag[i] = (g < 0) ? 38'(-g) : 38'(g);
            end
          end
          // scale so that every component fits 31 bits
          S_K: begin
            orm = tok_d[s].mag[0] | tok_d[s].mag[1] | tok_d[s].mag[2];
            tok_d[s].k = '0;
            for (int b = 1; b <= 7; b++) begin
              if ((orm >> (30 + b)) != '0) tok_d[s].k = 3'(b);
            end
            for (int i = 0; i < 3; i++) begin
              tok_d[s].sm[i] = 31'(tok_d[s].mag[i] >> tok_d[s].k);
            end
          end
          S_SQ: begin
            for (int i = 0; i < 3; i++) begin
              tok_d[s].sq[i] = 62'(tok_d[s].sm[i]) * 62'(tok_d[s].sm[i]);
            end
          end
          S_N: begin
            tok_d[s].n = 64'(tok_d[s].sq[0]) + 64'(tok_d[s].sq[1]) + 64'(tok_d[s].sq[2]);
            tok_d[s].res = '0;
          end
          // gap length, depth and divider operands
          S_LEN: begin
            tok_d[s].len = 39'(tok_d[s].res[31:0]) << tok_d[s].k;
            tok_d[s].e = 41'(tok_d[s].r) + 41'(tok_d[s].hh) - 41'(tok_d[s].len);
            for (int i = 0; i < 3; i++) begin
              tok_d[s].num[i] = (NUMW'(tok_d[s].mag[i]) << 14) + NUMW'(tok_d[s].len >> 1);
              tok_d[s].quo[i] = '0;
            end
          end
          // direction, overlap product and impact lever
          S_DIR: begin
            for (int i = 0; i < 3; i++) begin
              qc = (tok_d[s].quo[i] > 16'(Q14_ONE)) ? 16'(Q14_ONE) : tok_d[s].quo[i];
              if (tok_d[s].len == '0) begin
                tok_d[s].dir[i] = '0;
              end else begin
                tok_d[s].dir[i] = tok_d[s].neg[i] ? (16'd0 - qc) : qc;
              end
            end
            tok_d[s].epos = tok_d[s].e > 0;
            bv = $signed({11'b0, tok_d[s].r, 1'b0}) - 43'(tok_d[s].e);
            tok_d[s].apos = (tok_d[s].e > 0) && (bv > 0);
            tok_d[s].prod = 64'(tok_d[s].e[31:0]) * 64'(bv[31:0]);
            tok_d[s].w = 33'(tok_d[s].r) - 33'(tok_d[s].e >>> 1);
          end
          S_MUL: begin
            qa = tok_d[s].prod >> COORD_FRAC_BITS;
            tok_d[s].ah = AHW'(qa >> 16) * AHW'(PI_Q30);
            tok_d[s].al = 48'(qa[15:0]) * 48'(PI_Q30);
            for (int i = 0; i < 3; i++) begin
              tok_d[s].wd[i] = 49'(tok_d[s].w) * 49'(tok_d[s].dir[i]);
            end
          end
          // area, impact point, depth
          S_FIN: begin
            tot = (TOTW'(tok_d[s].ah) << 16) + TOTW'(tok_d[s].al);
            af = AFW'(tot >> 30);
            if (!tok_d[s].apos) begin
              tok_d[s].area = '0;
            end else if (af > AFW'(AREA_MAX)) begin
              tok_d[s].area = AREA_MAX;
            end else begin
              tok_d[s].area = 48'(af);
            end
            for (int i = 0; i < 3; i++) begin
              iv = 36'(tok_d[s].ca[i]) + 36'((tok_d[s].wd[i] + RND_HALF) >>> 14);
              tok_d[s].imp[i] = tok_d[s].epos ? sat32(64'(iv)) : '0;
            end
            tok_d[s].depth = sat32(64'(tok_d[s].e));
          end
          default: ;
        endcase
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      tok_q <= tok_d;
    end
  end

  // result packing
  always_comb begin
    out_d.impact_depth = tok_q[NSTG-1].depth;
    out_d.overlap_area = tok_q[NSTG-1].area;
    out_d.dir_x = tok_q[NSTG-1].dir[0];
    out_d.dir_y = tok_q[NSTG-1].dir[1];
    out_d.dir_z = tok_q[NSTG-1].dir[2];
    out_d.impact_x = tok_q[NSTG-1].imp[0];
    out_d.impact_y = tok_q[NSTG-1].imp[1];
    out_d.impact_z = tok_q[NSTG-1].imp[2];
    out_d.active = tok_q[NSTG-1].epos;
    out_d.unbalance = tok_q[NSTG-1].epos && !tok_q[NSTG-1].prev;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data = out_data_q;

`ifndef SYNTHESIS
  // a held result in both the last stage and the output blocks new items
  a_block_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready && vld_q[NSTG-1]) |-> !in_i.ready)
    else $error("item taken while pipeline full");

  // a stalled pipeline keeps every valid bit in place
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during stall");

  // a result without contact has no area, no impact point, no new contact
  a_no_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_data_q.active) |->
      (out_data_q.overlap_area == '0 && out_data_q.impact_x == '0 &&
       out_data_q.impact_y == '0 && out_data_q.impact_z == '0 &&
       !out_data_q.unbalance))
    else $error("contact outputs set without contact");

  // direction components stay within unit length
  a_dir_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |->
      ($signed(out_data_q.dir_x) <= 16'sd16384 && $signed(out_data_q.dir_x) >= -16'sd16384 &&
       $signed(out_data_q.dir_y) <= 16'sd16384 && $signed(out_data_q.dir_y) >= -16'sd16384 &&
       $signed(out_data_q.dir_z) <= 16'sd16384 && $signed(out_data_q.dir_z) >= -16'sd16384))
    else $error("direction component out of range");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_sphere_plate_contact_detect.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_sphere_plate_contact_detect
// Drives contact pairs through the detector under several plate settings,
// predicts every result in the bench and compares each output item field by
// field, with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sphere_plate_contact_detect;
  import spcd_pkg::*;

  localparam int FRAC = 16;
  localparam longint LIMIT = 400000;
  localparam int N_RAND = 1300;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spcd_in_if  in_ch ();
  spcd_out_if out_ch ();

  sphere_plate_contact_detect #(.COORD_FRAC_BITS(FRAC)) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch.sink),
    .out_o   (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // plate setting as seen by the predictor
  longint plate_zax [3];
  longint plate_xax [3];
  longint plate_w, plate_l;

  spcd_out_t result_q [$];
  int        mismatches;
  longint    cycle_cnt;
  bit        quiet;       // no idling at the end of the run
  bit        hold_req;    // ask for one long output hold-off
  bit        hold_done;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("tb_sphere_plate_contact_detect NOT OK");
      $finish;
    end
  end

  function automatic longint rnd14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint clamp_h(longint v, longint h);
    if (v < -h) return -h;
    if (v > h) return h;
    return v;
  endfunction

  function automatic longint sat_32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // contact prediction for one pair under the current plate setting
  function automatic spcd_out_t predict_contact(spcd_in_t c);
    spcd_out_t o;
    longint ca [3], d [3], p [3], gap [3], dir [3], pt [3], yax [3];
    longint unsigned mag [3];
    longint unsigned sum, area, prod, q, qh, ql, a_hi, b_lo, qd;
    longint r, hh, t, ax, ay, len, e, b, w;
    int k;
    r = longint'(c.sphere_radius);
    hh = longint'(c.plate_height) >>> 1;
    ca[0] = c.sphere_x; ca[1] = c.sphere_y; ca[2] = c.sphere_z;
    d[0] = ca[0] - longint'(c.plate_x);
    d[1] = ca[1] - longint'(c.plate_y);
    d[2] = ca[2] - longint'(c.plate_z);
    yax[0] = rnd14(plate_zax[1] * plate_xax[2] - plate_zax[2] * plate_xax[1]);
    yax[1] = rnd14(plate_zax[2] * plate_xax[0] - plate_zax[0] * plate_xax[2]);
    yax[2] = rnd14(plate_zax[0] * plate_xax[1] - plate_zax[1] * plate_xax[0]);
    t = rnd14(d[0] * plate_zax[0] + d[1] * plate_zax[1] + d[2] * plate_zax[2]);
    for (int i = 0; i < 3; i++) p[i] = d[i] - rnd14(t * plate_zax[i]);
    ax = clamp_h(rnd14(p[0] * plate_xax[0] + p[1] * plate_xax[1] + p[2] * plate_xax[2]),
                 plate_w >>> 1);
    ay = clamp_h(rnd14(p[0] * yax[0] + p[1] * yax[1] + p[2] * yax[2]), plate_l >>> 1);
    for (int i = 0; i < 3; i++) begin
      gap[i] = rnd14(plate_xax[i] * ax + yax[i] * ay) - d[i];
      mag[i] = gap[i] < 0 ? -gap[i] : gap[i];
    end
    k = 0;
    while ((mag[0] >> k) >= 64'd2147483648 || (mag[1] >> k) >= 64'd2147483648 ||
           (mag[2] >> k) >= 64'd2147483648) k++;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += (mag[i] >> k) * (mag[i] >> k);
    len = longint'(sqrt_floor(sum) << k);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        dir[i] = 0;
      end else begin
        qd = (mag[i] * 16384 + longint'(len) / 2) / longint'(len);
        if (qd > 16384) qd = 16384;
        dir[i] = gap[i] < 0 ? -longint'(qd) : longint'(qd);
      end
    end
    e = r + hh - len;
    area = 0;
    for (int i = 0; i < 3; i++) pt[i] = 0;
    if (e > 0) begin
      b = 2 * r - e;
      w = r - (e >>> 1);
      if (b > 0) begin
        prod = longint'(e) * longint'(b);
        q = prod >> FRAC;
        qh = q >> 16;
        ql = q & 64'hFFFF;
        a_hi = qh * 64'd3373259426;
        b_lo = ql * 64'd3373259426;
        area = (a_hi >> 14) + ((((a_hi & 64'h3FFF) << 16) + b_lo) >> 30);
        if (area > 64'hFFFF_FFFF_FFFF) area = 64'hFFFF_FFFF_FFFF;
      end
      for (int i = 0; i < 3; i++) pt[i] = sat_32(ca[i] + rnd14(w * dir[i]));
    end
    o.impact_depth = 32'(sat_32(e));
    o.overlap_area = area[47:0];
    o.dir_x = 16'(dir[0]); o.dir_y = 16'(dir[1]); o.dir_z = 16'(dir[2]);
    o.impact_x = 32'(pt[0]); o.impact_y = 32'(pt[1]); o.impact_z = 32'(pt[2]);
    o.active = (e > 0);
    o.unbalance = (e > 0) && !c.prev_active;
    return o;
  endfunction

  // register write over the apb port, keeps the predictor copy in step
  task automatic write_reg(reg_e idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_AXIS_Z_X:     plate_zax[0] = longint'($signed(val[15:0]));
      REG_AXIS_Z_Y:     plate_zax[1] = longint'($signed(val[15:0]));
      REG_AXIS_Z_Z:     plate_zax[2] = longint'($signed(val[15:0]));
      REG_AXIS_X_X:     plate_xax[0] = longint'($signed(val[15:0]));
      REG_AXIS_X_Y:     plate_xax[1] = longint'($signed(val[15:0]));
      REG_AXIS_X_Z:     plate_xax[2] = longint'($signed(val[15:0]));
      REG_PLATE_WIDTH:  plate_w = longint'(val[30:0]);
      REG_PLATE_LENGTH: plate_l = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_plate(int zx, int zy, int zz, int xx, int xy, int xz,
                           logic [31:0] w, logic [31:0] l);
    write_reg(REG_AXIS_Z_X, zx);
    write_reg(REG_AXIS_Z_Y, zy);
    write_reg(REG_AXIS_Z_Z, zz);
    write_reg(REG_AXIS_X_X, xx);
    write_reg(REG_AXIS_X_Y, xy);
    write_reg(REG_AXIS_X_Z, xz);
    write_reg(REG_PLATE_WIDTH, w);
    write_reg(REG_PLATE_LENGTH, l);
    // bus back to idle after the last access
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // stop offering items and wait for the pipeline to drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  // send one pair, with an optional idle burst before it
  task automatic send_pair(spcd_in_t c, bit chk_fixed, spcd_out_t fixed);
    spcd_out_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= c;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    pred = predict_contact(c);
    if (chk_fixed && fixed != pred) begin
      mismatches++;
      if (mismatches <= 10) $display("table row exp %h pred %h", fixed, pred);
    end
    result_q.push_back(chk_fixed ? fixed : pred);
  endtask

  // output side: random stalls and one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    spcd_out_t want, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = result_q.pop_front();
        if (got.impact_depth !== want.impact_depth || got.overlap_area !== want.overlap_area ||
            got.dir_x !== want.dir_x || got.dir_y !== want.dir_y ||
            got.dir_z !== want.dir_z || got.impact_x !== want.impact_x ||
            got.impact_y !== want.impact_y || got.impact_z !== want.impact_z ||
            got.active !== want.active || got.unbalance !== want.unbalance) begin
          mismatches++;
          if (mismatches <= 10) $display("result mismatch exp %h got %h", want, got);
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 400000) - 200000;
      default: return $urandom_range(0, 8000000) - 4000000;
    endcase
  endfunction

  function automatic spcd_in_t rand_pair();
    spcd_in_t c;
    int m;
    m = $urandom_range(0, 5);
    if (m == 0) m = 0; else if (m < 3) m = 1; else m = 2;
    c.sphere_x = rand_coord(m); c.sphere_y = rand_coord(m); c.sphere_z = rand_coord(m);
    c.plate_x = rand_coord(m); c.plate_y = rand_coord(m); c.plate_z = rand_coord(m);
    c.sphere_radius = (m == 0) ? 31'($urandom()) : 31'($urandom_range(0, 300000));
    c.plate_height = (m == 0) ? 31'($urandom()) : 31'($urandom_range(0, 200000));
    c.prev_active = 1'($urandom_range(0, 1));
    return c;
  endfunction

  typedef struct {
    spcd_in_t  pair;
    bit        fixed;
    spcd_out_t res;
  } row_t;

  row_t dir_rows [$];

  initial begin
    spcd_in_t c;
    row_t rw;
    spcd_out_t z;
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.data = '0;
    cycle_cnt = 0; mismatches = 0; quiet = 0; hold_req = 0; hold_done = 0;
    plate_zax[0] = 0; plate_zax[1] = 0; plate_zax[2] = 16384;
    plate_xax[0] = 16384; plate_xax[1] = 0; plate_xax[2] = 0;
    plate_w = 65536; plate_l = 65536;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset plate
    z = '0;
    // sphere at the plate centre: zero gap, depth r + h/2, area 0.75 pi
    c = '0; c.sphere_radius = 31'd65536; c.plate_height = 31'd65536;
    rw.pair = c; rw.fixed = 1'b1; rw.res = z;
    rw.res.impact_depth = 98304; rw.res.overlap_area = 48'd154415;
    rw.res.active = 1'b1; rw.res.unbalance = 1'b1;
    dir_rows.push_back(rw);
    // same, previously active
    c.prev_active = 1'b1; rw.pair = c; rw.res.unbalance = 1'b0;
    dir_rows.push_back(rw);
    // all zero: no contact, zero gap
    c = '0; rw.pair = c; rw.res = z; dir_rows.push_back(rw);
    // sphere far above: no contact, straight down
    c = '0; c.sphere_z = 32'sh00100000; c.sphere_radius = 31'd65536;
    rw.pair = c; rw.res = z; rw.res.impact_depth = -983040; rw.res.dir_z = -16'sd16384;
    dir_rows.push_back(rw);
    rw.fixed = 1'b0;
    // extremes of the fields
    c = '0; c.sphere_x = 32'sh7fffffff; c.plate_x = 32'sh80000000;
    c.sphere_radius = 31'h7fffffff; c.plate_height = 31'h7fffffff;
    rw.pair = c; dir_rows.push_back(rw);
    c = '1; rw.pair = c; dir_rows.push_back(rw);
    c = '0; c.sphere_y = 32'sh80000000; c.sphere_z = 32'sh7fffffff;
    c.plate_y = 32'sh7fffffff; c.plate_z = 32'sh80000000; c.sphere_radius = 31'h7fffffff;
    rw.pair = c; dir_rows.push_back(rw);
    // deep penetration past 2r: no area
    c = '0; c.sphere_radius = 31'd100; c.plate_height = 31'h01000000;
    rw.pair = c; dir_rows.push_back(rw);
    // off the plate edge, clamped both ways
    c = '0; c.sphere_x = 32'sh00030000; c.sphere_y = -32'sh00020000;
    c.sphere_z = 32'sh00008000; c.sphere_radius = 31'h0003_0000;
    rw.pair = c; dir_rows.push_back(rw);
    c.sphere_x = -32'sh00050000; c.sphere_y = 32'sh00050000; c.prev_active = 1'b1;
    rw.pair = c; dir_rows.push_back(rw);
    // very large area, still below the 48-bit saturation limit
    c = '0; c.sphere_radius = 31'h40000000; c.plate_height = 31'h40000000;
    c.sphere_z = 32'sh10000000; rw.pair = c; dir_rows.push_back(rw);
    foreach (dir_rows[i]) send_pair(dir_rows[i].pair, dir_rows[i].fixed, dir_rows[i].res);

    // random phases under several plate settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: set_plate(0, 0, 16384, 16384, 0, 0, 65536, 65536);
        1: set_plate(16384, 0, 0, 0, 16384, 0, 200000, 131073);
        2: set_plate(11585, 0, 11585, 11585, 0, -11585, 1, 0);
        3: set_plate(-16384, -16384, -16384, 16384, 16384, 16384,
                     32'h7fffffff, 32'h7fffffff);
        4: set_plate(32767, -32768, 0, -32768, 32767, 1, 32'h7fffffff, 0);
        default: set_plate($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom(), $urandom());
      endcase
      if (ph == 5) quiet = 1'b1;
      for (int n = 0; n < N_RAND / 6; n++) begin
        if (ph == 2 && n == 40) hold_req = 1'b1;
        send_pair(rand_pair(), 1'b0, z);
      end
    end
    drain();
    if (mismatches == 0) begin
      $display("tb_sphere_plate_contact_detect OK");
    end else begin
      $display("tb_sphere_plate_contact_detect NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
